[design/i2cgx_pkg.sv]
// ----------------------------------------------------------------------------
// i2cgx_pkg
// Types and constants shared by the I2C slave GPIO expander modules.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cgx_pkg;

  localparam logic [6:0] SLAVE_ADDR_RESET = 7'h42;
  localparam int         CFG_AW           = 1;
  localparam int         CFG_DW           = 32;
  localparam int         IN_DW            = 16;
  localparam int         OUT_DW           = 16;

  // Register byte addresses on the configuration port.
  localparam logic [CFG_AW-1:0] REG_SLAVE_ADDR = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ADDR     = 3'd1,
    PH_ADDR_ACK = 3'd2,
    PH_SEND     = 3'd3,
    PH_MST_ACK  = 3'd4,
    PH_RECV     = 3'd5,
    PH_DATA_ACK = 3'd6
  } phase_t;

  typedef struct packed {
    logic       sda_pull_low;
    logic [7:0] pin_drive;
    logic       pins_are_outputs;
  } result_t;

endpackage

`default_nettype wire

[design/i2cgx_core.sv]
// ----------------------------------------------------------------------------
// i2cgx_core
// Bus state tracker: start/stop detection, address match, one data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cgx_core
  import i2cgx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_accept,
  input  wire logic       scl_level,
  input  wire logic       sda_level,
  input  wire logic [7:0] pin_levels,
  input  wire logic [6:0] slave_address,
  output result_t         result_nxt
);

  phase_t     phase_r,    phase_nxt;
  logic [3:0] bit_cnt_r,  bit_cnt_nxt;
  logic [7:0] shift_r,    shift_nxt;
  logic       rd_req_r,   rd_req_nxt;
  logic [7:0] latch_r,    latch_nxt;
  logic       out_mode_r, out_mode_nxt;
  logic       prev_scl_r, prev_sda_r;

  logic       high_held, start_c, stop_c, rise_c, fall_c;
  logic [3:0] bit_inc;

  assign high_held = prev_scl_r & scl_level;
  assign start_c   = high_held & prev_sda_r & ~sda_level;
  assign stop_c    = high_held & ~prev_sda_r & sda_level;
  assign rise_c    = ~prev_scl_r & scl_level;
  assign fall_c    = prev_scl_r & ~scl_level;
  assign bit_inc   = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    rd_req_nxt   = rd_req_r;
    latch_nxt    = latch_r;
    out_mode_nxt = out_mode_r;
    if (start_c) begin
      phase_nxt   = PH_ADDR;
      bit_cnt_nxt = 4'd0;
      shift_nxt   = 8'd0;
    end else if (stop_c) begin
      phase_nxt   = PH_IDLE;
      bit_cnt_nxt = 4'd0;
    end else begin
      case (phase_r)
        PH_ADDR, PH_RECV: begin
          if (rise_c && !bit_cnt_r[3]) begin
            shift_nxt   = {shift_r[6:0], sda_level};
            bit_cnt_nxt = bit_inc;
          end else if (fall_c && bit_cnt_r[3]) begin
            bit_cnt_nxt = 4'd0;
            if (phase_r == PH_RECV) begin
              phase_nxt = PH_DATA_ACK;
            end else if (shift_r[7:1] == slave_address) begin
              rd_req_nxt = shift_r[0];
              if (shift_r[0]) begin
                // A read turns every pin into an input and snapshots them.
                latch_nxt    = 8'd0;
                out_mode_nxt = 1'b0;
                shift_nxt    = pin_levels;
              end else begin
                out_mode_nxt = 1'b1;
              end
              phase_nxt = PH_ADDR_ACK;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_ADDR_ACK: begin
          if (fall_c) begin
            bit_cnt_nxt = 4'd0;
            phase_nxt   = rd_req_r ? PH_SEND : PH_RECV;
          end
        end
        PH_SEND: begin
          if (fall_c) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            if (bit_inc[3]) begin
              bit_cnt_nxt = 4'd0;
              phase_nxt   = PH_MST_ACK;
            end else begin
              bit_cnt_nxt = bit_inc;
            end
          end
        end
        PH_MST_ACK: begin
          if (fall_c) phase_nxt = PH_IDLE;
        end
        PH_DATA_ACK: begin
          if (fall_c) begin
            latch_nxt = shift_r;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (phase_nxt)
      PH_ADDR_ACK, PH_DATA_ACK: result_nxt.sda_pull_low = 1'b1;
      PH_SEND:                  result_nxt.sda_pull_low = ~shift_nxt[7];
      default:                  result_nxt.sda_pull_low = 1'b0;
    endcase
    result_nxt.pin_drive        = latch_nxt;
    result_nxt.pins_are_outputs = out_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      rd_req_r   <= 1'b0;
      latch_r    <= 8'd0;
      out_mode_r <= 1'b0;
      prev_scl_r <= 1'b1;
      prev_sda_r <= 1'b1;
    end else if (item_accept) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      rd_req_r   <= rd_req_nxt;
      latch_r    <= latch_nxt;
      out_mode_r <= out_mode_nxt;
      prev_scl_r <= scl_level;
      prev_sda_r <= sda_level;
    end
  end

endmodule

`default_nettype wire

[design/i2c_slave_gpio_expander_top.sv]
// A result appears on the out channel in the cycle after its sample transfer.
// Throughput: one sample per cycle; the state update and result logic sit between
// the bus state registers and the output register.
// The input is held off only while a result waits and out_tready is low.
// Reset (synchronous, active low) idles the bus tracker, makes all pins inputs,
// clears the latch and restores the slave address to 0x42.
// ----------------------------------------------------------------------------
// i2c_slave_gpio_expander_top
// I2C slave 8-bit GPIO expander on a streaming sample interface with APB setup.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_slave_gpio_expander_top
  import i2cgx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // in_tdata: [0] scl_level, [1] sda_level, [9:2] pin_levels, [15:10] zero
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,
  // out_tdata: [0] sda_pull_low, [8:1] pin_drive, [9] pins_are_outputs,
  //            [10] mode_led, [15:11] zero
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [6:0]        slave_addr_r;
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic              accept;
  logic              cfg_wr;
  result_t           result_nxt;

  assign in_tready  = ~out_valid_r | out_tready;
  assign accept     = in_tvalid & in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = {{(CFG_DW-7){1'b0}}, slave_addr_r};

  i2cgx_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_accept   (accept),
    .scl_level     (in_tdata[0]),
    .sda_level     (in_tdata[1]),
    .pin_levels    (in_tdata[9:2]),
    .slave_address (slave_addr_r),
    .result_nxt    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RESET;
    end else if (cfg_wr && cfg_paddr == REG_SLAVE_ADDR) begin
      slave_addr_r <= cfg_pwdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {5'd0, result_nxt.pins_are_outputs, result_nxt.pins_are_outputs,
                     result_nxt.pin_drive, result_nxt.sda_pull_low};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[design/i2cgx_checker.sv]
// ----------------------------------------------------------------------------
// i2cgx_checker
// Port-level checks for the GPIO expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cgx_checker
  import i2cgx_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata
);

  // Every accepted sample produces a result in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted sample produced no result");

  // The indicator always mirrors the pin direction.
  a_led_mirrors_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10] == out_tdata[9])
    else $error("mode_led differs from pins_are_outputs");

  // While pins are inputs the latch is always clear.
  a_input_mode_latch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[9] |-> out_tdata[8:1] == 8'd0)
    else $error("latch not clear while pins are inputs");

  // A pending result that is not taken stays unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind i2c_slave_gpio_expander_top i2cgx_checker u_i2cgx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[verif/tb_i2c_slave_gpio_expander_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_slave_gpio_expander_top
// Drives oversampled SCL/SDA line samples into the I2C GPIO expander and
// checks every output word against a cycle-level model of the slave. The
// stimulus is built from bus transfers: reads, writes, foreign addresses,
// transfers cut short by a stop or a new start, and line noise, under
// several slave addresses and with random stalls on both streams.
// ----------------------------------------------------------------------------

module tb_i2c_slave_gpio_expander_top;
  import i2cgx_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_TAIL  = 4;
  localparam int NO_CUT      = 99;
  localparam logic RW_WRITE  = 1'b0;
  localparam logic RW_READ   = 1'b1;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] pins;
    logic       hold;   // wait for all outstanding results before this sample
  } sample_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  // in_tdata: [0] scl_level, [1] sda_level, [9:2] pin_levels, [15:10] zero
  logic [IN_DW-1:0]    in_tdata    = '0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  // out_tdata: [0] sda_pull_low, [8:1] pin_drive, [9] pins_are_outputs,
  //            [10] mode_led, [15:11] zero
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [CFG_DW-1:0]   cfg_pwdata  = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  i2c_slave_gpio_expander_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Slave model state.
  phase_t     m_phase  = PH_IDLE;
  logic [3:0] m_bits   = '0;
  logic [7:0] m_shift  = '0;
  logic       m_read   = 1'b0;
  logic [7:0] m_latch  = '0;
  logic       m_outs   = 1'b0;
  logic       m_scl    = 1'b1;
  logic       m_sda    = 1'b1;
  logic [6:0] m_addr   = SLAVE_ADDR_RESET;

  result_t    pin_results[$];
  sample_t    line_samples[$];
  sample_t    cur_sample;
  logic       hold_next    = 1'b0;
  logic [6:0] cur_addr     = SLAVE_ADDR_RESET;

  int n_queued = 0;
  int n_sent   = 0;
  int n_seen   = 0;
  int n_errors = 0;
  int n_acked  = 0;
  int n_reads  = 0;
  int n_latched = 0;
  int cycle_count = 0;

  logic sent_now;
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;
  int   send_gap  = 0;
  int   recv_wait = 0;
  int   recv_draw;

  task automatic log_mismatch(input string what);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic int pick_wait(input logic calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] pick_pins();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Advances the slave model by one line sample and queues the output word.
  task automatic model_sample(input sample_t s);
    logic    held, is_start, is_stop, rise, fall;
    result_t r;
    held     = m_scl && s.scl;
    is_start = held && m_sda && !s.sda;
    is_stop  = held && !m_sda && s.sda;
    rise     = !m_scl && s.scl;
    fall     = m_scl && !s.scl;
    if (is_start) begin
      m_phase = PH_ADDR;
      m_bits  = '0;
      m_shift = '0;
    end else if (is_stop) begin
      m_phase = PH_IDLE;
      m_bits  = '0;
    end else begin
      case (m_phase)
        PH_ADDR, PH_RECV: begin
          if (rise && m_bits < 8) begin
            m_shift = {m_shift[6:0], s.sda};
            m_bits  = m_bits + 4'd1;
          end else if (fall && m_bits >= 8) begin
            m_bits = '0;
            if (m_phase == PH_RECV) begin
              m_phase = PH_DATA_ACK;
            end else if (m_shift[7:1] == m_addr) begin
              m_read = m_shift[0];
              n_acked++;
              if (m_read) begin
                m_latch = '0;
                m_outs  = 1'b0;
                m_shift = s.pins;
                n_reads++;
              end else begin
                m_outs = 1'b1;
              end
              m_phase = PH_ADDR_ACK;
            end else begin
              m_phase = PH_IDLE;
            end
          end
        end
        PH_ADDR_ACK: begin
          if (fall) begin
            m_bits  = '0;
            m_phase = m_read ? PH_SEND : PH_RECV;
          end
        end
        PH_SEND: begin
          if (fall) begin
            m_shift = {m_shift[6:0], 1'b0};
            m_bits  = m_bits + 4'd1;
            if (m_bits >= 8) begin
              m_bits  = '0;
              m_phase = PH_MST_ACK;
            end
          end
        end
        PH_MST_ACK: begin
          if (fall)
            m_phase = PH_IDLE;
        end
        PH_DATA_ACK: begin
          if (fall) begin
            m_latch = m_shift;
            m_phase = PH_IDLE;
            n_latched++;
          end
        end
        default: ;
      endcase
    end
    m_scl = s.scl;
    m_sda = s.sda;

    if (m_phase == PH_ADDR_ACK || m_phase == PH_DATA_ACK)
      r.sda_pull_low = 1'b1;
    else if (m_phase == PH_SEND)
      r.sda_pull_low = ~m_shift[7];
    else
      r.sda_pull_low = 1'b0;
    r.pin_drive        = m_latch;
    r.pins_are_outputs = m_outs;
    pin_results.push_back(r);
  endtask

  task automatic check_output(input logic [OUT_DW-1:0] d);
    result_t want;
    if (pin_results.size() == 0) begin
      log_mismatch($sformatf("output word %h with no sample outstanding", d));
    end else begin
      want = pin_results.pop_front();
      if (d[0] !== want.sda_pull_low)
        log_mismatch($sformatf("sda_pull_low %b, expected %b", d[0], want.sda_pull_low));
      if (d[8:1] !== want.pin_drive)
        log_mismatch($sformatf("pin_drive %h, expected %h", d[8:1], want.pin_drive));
      if (d[9] !== want.pins_are_outputs)
        log_mismatch($sformatf("pins_are_outputs %b, expected %b", d[9],
                               want.pins_are_outputs));
      if (d[10] !== want.pins_are_outputs)
        log_mismatch($sformatf("mode_led %b, expected %b", d[10], want.pins_are_outputs));
    end
  endtask

  // Sample driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
      n_sent    <= 0;
    end else begin
      sent_now = in_tvalid && in_tready;
      if (sent_now) begin
        model_sample(cur_sample);
        n_sent <= n_sent + 1;
      end
      if (!in_tvalid || sent_now) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (line_samples.size() != 0 &&
                     !(line_samples[0].hold && (sent_now || n_sent != n_seen))) begin
          cur_sample = line_samples.pop_front();
          in_tdata  <= {6'd0, cur_sample.pins, cur_sample.sda, cur_sample.scl};
          in_tvalid <= 1'b1;
          send_gap  <= pick_wait(send_calm);
          if ($urandom_range(0, 199) == 0)
            send_calm <= ~send_calm;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait  <= 0;
      n_seen     <= 0;
    end else if (out_tvalid && out_tready) begin
      check_output(out_tdata);
      n_seen <= n_seen + 1;
      if ($urandom_range(0, 199) == 0)
        recv_calm <= ~recv_calm;
      recv_draw = pick_wait(recv_calm);
      if (recv_draw == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        recv_wait  <= recv_draw;
      end
    end else if (!out_tready) begin
      if (recv_wait <= 1) begin
        out_tready <= 1'b1;
        recv_wait  <= 0;
      end else begin
        recv_wait <= recv_wait - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("i2c_slave_gpio_expander_top test failed");
      $finish;
    end
  end

  // Stimulus building blocks: queue_sample queues one line sample; the others queue a bit, a start or a stop.
  task automatic queue_sample(input logic scl, input logic sda);
    sample_t s;
    s.scl  = scl;
    s.sda  = sda;
    s.pins = pick_pins();
    s.hold = hold_next;
    hold_next = 1'b0;
    line_samples.push_back(s);
    n_queued++;
  endtask

  task automatic queue_bit(input logic b);
    repeat ($urandom_range(1, 2)) queue_sample(1'b0, b);
    repeat ($urandom_range(1, 2)) queue_sample(1'b1, b);
  endtask

  task automatic queue_start();
    queue_sample(1'b0, 1'b1);
    queue_sample(1'b1, 1'b1);
    queue_sample(1'b1, 1'b0);
  endtask

  task automatic queue_stop();
    queue_sample(1'b0, 1'b0);
    queue_sample(1'b1, 1'b0);
    queue_sample(1'b1, 1'b1);
  endtask

  // One bus transfer with a single data byte. A cut before the last bit ends
  // it early with a stop or a new start; a complete one ends with a stop or
  // is left open for a repeated start.
  task automatic queue_transfer(input logic [6:0] a, input logic rw, input logic [7:0] data,
                                input int cut, input logic end_stop);
    logic bits[$];
    for (int i = 6; i >= 0; i--) bits.push_back(a[i]);
    bits.push_back(rw);
    bits.push_back(($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
    for (int i = 7; i >= 0; i--)
      bits.push_back(rw == RW_READ ? 1'($urandom_range(0, 1)) : data[i]);
    bits.push_back(1'($urandom_range(0, 1)));
    queue_start();
    for (int i = 0; i < bits.size() && i < cut; i++)
      queue_bit(bits[i]);
    if (cut < bits.size()) begin
      if (end_stop)
        queue_stop();
      else
        queue_start();
    end else if (end_stop) begin
      queue_stop();
    end
  endtask

  task automatic random_traffic(input int n_items);
    int target;
    target = n_queued + n_items;
    while (n_queued < target) begin
      hold_next = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(3, 20))
             queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1: queue_transfer(cur_addr, 1'($urandom_range(0, 1)), pick_pins(),
                          $urandom_range(0, 17), 1'($urandom_range(0, 1)));
        default:
          queue_transfer(($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : cur_addr,
                         1'($urandom_range(0, 1)), pick_pins(), NO_CUT,
                         $urandom_range(0, 3) != 0);
      endcase
    end
    queue_stop();
  endtask

  task automatic wait_quiet();
    while (n_sent != n_queued || n_seen != n_sent) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Writes the slave address and reads it back; only called while idle.
  task automatic set_slave_address(input logic [6:0] a);
    for (int rd = 0; rd < 2; rd++) begin
      @(posedge clk);
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= (rd == 0);
      cfg_paddr   <= REG_SLAVE_ADDR;
      cfg_pwdata  <= {{(CFG_DW-7){1'b0}}, a};
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      if (rd == 0) begin
        m_addr   = a;
        cur_addr = a;
      end else if (cfg_prdata[6:0] !== a) begin
        log_mismatch($sformatf("slave address reads %h, written %h", cfg_prdata[6:0], a));
      end
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed transfers at the reset address and at one foreign address.
    hold_next = 1'b1;
    queue_transfer(cur_addr, RW_WRITE, 8'hFF, NO_CUT, 1'b1);
    queue_transfer(cur_addr, RW_READ, 8'h00, NO_CUT, 1'b1);
    queue_transfer(cur_addr, RW_WRITE, 8'h00, NO_CUT, 1'b0);
    queue_transfer(cur_addr ^ 7'h01, RW_WRITE, 8'hA5, NO_CUT, 1'b1);
    queue_transfer(cur_addr, RW_WRITE, 8'h5A, 12, 1'b1);
    queue_transfer(cur_addr, RW_READ, 8'h00, 13, 1'b0);
    queue_stop();
    queue_start();
    queue_stop();
    random_traffic(280);
    wait_quiet();

    set_slave_address(7'h00);
    random_traffic(280);
    wait_quiet();

    set_slave_address(7'h7F);
    random_traffic(280);
    wait_quiet();

    set_slave_address(7'($urandom_range(1, 126)));
    random_traffic(280);
    wait_quiet();

    if (pin_results.size() != 0)
      log_mismatch($sformatf("%0d output words never arrived", pin_results.size()));
    $display("Ran %0d line samples over four slave addresses in %0d cycles.",
             n_sent, cycle_count);
    $display("Address matches %0d, reads %0d, bytes latched %0d, mismatches %0d.",
             n_acked, n_reads, n_latched, n_errors);
    if (n_errors == 0)
      $display("i2c_slave_gpio_expander_top test passed");
    else
      $display("i2c_slave_gpio_expander_top test failed");
    $finish;
  end

endmodule
